[rtl/vgs_pkg.sv]
// Shared constants, types and helper functions of the voxel grid store and collision core.
// No dependencies; vgs_hit and the top level import this package (vgs_ram does not).
package vgs_pkg;

  localparam int unsigned GRID_DIM  = 16;                 // cells per axis
  localparam int unsigned CELL_W    = $clog2(GRID_DIM);
  localparam int unsigned ADDR_W    = 3 * CELL_W;
  localparam int unsigned CELLS     = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ORG_W     = 24;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned REL_W     = POS_W + 1;          // position minus origin
  localparam int unsigned FL_W      = REL_W - FRAC_W;     // whole-cell part
  localparam int unsigned DIST_W    = 18;
  localparam int unsigned SQ_W      = 2 * DIST_W;
  localparam int unsigned RAD_W     = 16;
  localparam int unsigned R2_W      = 2 * RAD_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_W      = 232;
  localparam int unsigned OUT_W     = 8;

  localparam logic [CELL_W-1:0] CELL_MAX     = CELL_W'(GRID_DIM - 1);
  localparam logic [CELL_W-1:0] CLAMP_HI     = CELL_W'(GRID_DIM - 2);
  localparam logic [CELL_W-1:0] CLAMP_HI_BOX = CELL_W'(GRID_DIM - 3);
  localparam logic [CELL_W-1:0] GROUND_ROWS  = CELL_W'(5);

  localparam logic [TYPE_W-1:0] TYPE_EMPTY  = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_GROUND = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_FILL   = 2'd2;

  localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'(1) << (DIST_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_FILL   = 3'd2,
    KIND_SURR   = 3'd3,
    KIND_SPHERE = 3'd4,
    KIND_BOX    = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_WB, ST_FILL, ST_SURR, ST_SDRAIN,
    ST_PREP1, ST_PREP2, ST_SCAN, ST_DRAIN, ST_OUT
  } state_e;

  typedef struct packed {
    logic              rejected;
    logic              hit;
    logic              surrounded;
    logic              changed;
    logic [TYPE_W-1:0] block_type;
  } result_t;

  // one scanned cell on its way into the hit unit
  typedef struct packed {
    logic              valid;
    logic              box;
    logic [2:0]        box_ok;
    logic [DIST_W-1:0] dx;
    logic [DIST_W-1:0] dy;
    logic [DIST_W-1:0] dz;
  } probe_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y,
                                                  logic [CELL_W-1:0] z);
    return {y, x, z};
  endfunction

  function automatic logic [TYPE_W-1:0] fill_type(logic [CELL_W-1:0] y, logic [VAL_W-1:0] h);
    if ({{(VAL_W-CELL_W){1'b0}}, y} > h) return TYPE_EMPTY;
    return (y < GROUND_ROWS) ? TYPE_GROUND : TYPE_FILL;
  endfunction

  // position relative to the chunk origin, 8 fraction bits
  function automatic logic signed [REL_W-1:0] rel_pos(logic [POS_W-1:0] p, logic [ORG_W-1:0] o);
    return $signed({p[POS_W-1], p}) - $signed({o[ORG_W-1], o, {FRAC_W{1'b0}}});
  endfunction

  // floor to whole cells, clamped to 1..hi
  function automatic logic [CELL_W-1:0] clamp_cell(logic signed [REL_W-1:0] t,
                                                   logic [CELL_W-1:0] hi);
    logic signed [FL_W-1:0] f;
    f = $signed(t[REL_W-1:FRAC_W]);
    if (f < $signed(FL_W'(1))) return CELL_W'(1);
    if (f > $signed({{(FL_W-CELL_W){1'b0}}, hi})) return hi;
    return f[CELL_W-1:0];
  endfunction

  function automatic logic signed [REL_W:0] cube_lo(logic [CELL_W-1:0] c);
    return $signed({{(REL_W+1-CELL_W-FRAC_W){1'b0}}, c, {FRAC_W{1'b0}}});
  endfunction

  // distance from a point to a unit cell along one axis, saturated
  function automatic logic [DIST_W-1:0] axis_dist(logic signed [REL_W-1:0] t,
                                                  logic [CELL_W-1:0] c);
    logic signed [REL_W:0] lo;
    logic signed [REL_W:0] hi;
    logic signed [REL_W:0] d;
    lo = cube_lo(c);
    hi = lo + (REL_W+1)'(1 << FRAC_W);
    if (t < lo) d = lo - t;
    else if (t > hi) d = t - hi;
    else d = '0;
    return (|d[REL_W:DIST_W-1]) ? DIST_SAT : d[DIST_W-1:0];
  endfunction

  // strict overlap of box interval with a unit cell along one axis
  function automatic logic box_axis(logic signed [REL_W-1:0] ta, logic signed [REL_W-1:0] tb,
                                    logic [CELL_W-1:0] c);
    logic signed [REL_W:0] lo;
    lo = cube_lo(c);
    return (tb > lo) && (ta < lo + (REL_W+1)'(1 << FRAC_W));
  endfunction

endpackage

[rtl/voxel_grid_store_and_collision_core.sv]
// Top level of the voxel grid store and collision core: sequencer, grid memory, hit unit.
// Depends on vgs_pkg, vgs_ram and vgs_hit.
//
// A 16x16x16 grid of 2-bit block types lives in one synchronous RAM (one write and one read
// port, registered read). After reset a clearing pass writes every one of the 4096 cells
// to empty, one per cycle; no item is taken during the pass, while origin writes are
// accepted. Each item then runs to completion before the next is taken: read and write
// go through read, modify/write back and result; column fill writes one row per cycle
// over 16 rows, then gives the result; surround query makes seven reads, one per cycle,
// then a drain state and the result; sphere and box tests pass setup states PREP1 and
// PREP2, read one cell per cycle over 27 or 36 cells, drain the hit pipeline, then give
// the result. Each item is taken in the idle state. The result sits in an output register,
// so a new item is taken while the last result still waits.
module voxel_grid_store_and_collision_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg: origin_x, origin_y, origin_z by index
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vgs_pkg::ORG_W-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: cell_x[3:0] cell_y[7:4] cell_z[11:8] value[19:12] ax[51:20] ay[83:52]
  //        az[115:84] bx[147:116] by[179:148] bz[211:180] radius[227:212], zero pad
  input  logic [vgs_pkg::IN_W-1:0]       s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [vgs_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: block_type[1:0] changed[2] surrounded[3] hit[4] rejected[5], zero pad
  output logic [vgs_pkg::OUT_W-1:0]      m_axis_tdata
);
  import vgs_pkg::*;

  // neighbour tags of the surround query
  localparam logic [2:0] NB_CENTER = 3'd0;
  localparam logic [2:0] NB_YP     = 3'd1;
  localparam logic [2:0] NB_YM     = 3'd2;
  localparam logic [2:0] NB_XP     = 3'd3;
  localparam logic [2:0] NB_XM     = 3'd4;
  localparam logic [2:0] NB_ZM     = 3'd5;
  localparam logic [2:0] NB_ZP     = 3'd6;
  localparam logic [1:0] OFF_LAST     = 2'd2;
  localparam logic [1:0] OFF_LAST_BOX = 2'd3;

  state_e state_q, state_d;

  // latched item
  kind_e             kind_q;
  logic [CELL_W-1:0] cx_q, cy_q, cz_q;
  logic [VAL_W-1:0]  val_q;
  logic [POS_W-1:0]  ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic [RAD_W-1:0]  rad_q;

  logic [ORG_W-1:0]  org_x_q, org_y_q, org_z_q;

  // scan setup
  logic signed [REL_W-1:0] tax_q, tay_q, taz_q, tbx_q, tby_q, tbz_q;
  logic [R2_W-1:0]   r2_q;
  logic [CELL_W-1:0] rx_q, ry_q, rz_q;
  logic [1:0]        ox_q, oy_q, oz_q;
  logic [1:0]        drain_q;
  logic [CELL_W-1:0] scx, scy, scz;
  logic              scan_last;

  logic [ADDR_W-1:0] cnt_q;
  logic              rd_vld_q;
  logic [2:0]        rd_tag_q;
  logic              surr_all_q;
  logic              interior;

  result_t           res_q, out_d, out_q;
  logic              m_valid_q;
  logic              push;

  // memory and hit unit
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [TYPE_W-1:0] ram_wdata, ram_rdata;
  probe_t            probe;
  logic              hit_clr, hit;
  logic              wr_en;
  logic              accept;

  vgs_ram #(.DATA_W(TYPE_W), .DEPTH(CELLS)) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  vgs_hit u_hit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (hit_clr),
    .probe_i(probe),
    .rdata_i(ram_rdata),
    .r2_i   (r2_q),
    .hit_o  (hit)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign push     = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign interior = (cx_q != '0) && (cx_q != CELL_MAX) && (cy_q != '0) &&
                    (cy_q != CELL_MAX) && (cz_q != '0) && (cz_q != CELL_MAX);

  // write modifies only empty->filled or filled->empty
  assign wr_en = (kind_q == KIND_WRITE) && (val_q <= VAL_W'(3)) &&
                 ((val_q != '0) ? (ram_rdata == TYPE_EMPTY) : (ram_rdata != TYPE_EMPTY));

  // scanned cell around the clamped reference cell
  assign scx       = rx_q + CELL_W'(ox_q) - CELL_W'(1);
  assign scy       = ry_q + CELL_W'(oy_q) - CELL_W'(1);
  assign scz       = rz_q + CELL_W'(oz_q) - CELL_W'(1);
  assign scan_last = (oz_q == OFF_LAST) && (ox_q == OFF_LAST) &&
                     (oy_q == ((kind_q == KIND_BOX) ? OFF_LAST_BOX : OFF_LAST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr(cx_q, cy_q, cz_q);
    ram_wdata     = TYPE_EMPTY;
    ram_raddr     = cell_addr(cx_q, cy_q, cz_q);
    probe         = '0;
    hit_clr       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        if (cnt_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            KIND_WRITE, KIND_READ:  state_d = ST_RD;
            KIND_FILL:              state_d = ST_FILL;
            KIND_SURR:              state_d = ST_SURR;
            KIND_SPHERE, KIND_BOX:  state_d = ST_PREP1;
            default:                state_d = ST_OUT;
          endcase
        end
      end
      ST_RD: state_d = ST_WB;
      ST_WB: begin
        ram_we    = wr_en;
        ram_wdata = val_q[TYPE_W-1:0];
        state_d   = ST_OUT;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(cx_q, cnt_q[CELL_W-1:0], cz_q);
        ram_wdata = fill_type(cnt_q[CELL_W-1:0], val_q);
        if (cnt_q[CELL_W-1:0] == CELL_MAX) state_d = ST_OUT;
      end
      ST_SURR: begin
        case (cnt_q[2:0])
          NB_YP:   ram_raddr = cell_addr(cx_q, cy_q + CELL_W'(1), cz_q);
          NB_YM:   ram_raddr = cell_addr(cx_q, cy_q - CELL_W'(1), cz_q);
          NB_XP:   ram_raddr = cell_addr(cx_q + CELL_W'(1), cy_q, cz_q);
          NB_XM:   ram_raddr = cell_addr(cx_q - CELL_W'(1), cy_q, cz_q);
          NB_ZM:   ram_raddr = cell_addr(cx_q, cy_q, cz_q - CELL_W'(1));
          NB_ZP:   ram_raddr = cell_addr(cx_q, cy_q, cz_q + CELL_W'(1));
          default: ram_raddr = cell_addr(cx_q, cy_q, cz_q);
        endcase
        if (cnt_q[2:0] == NB_ZP) state_d = ST_SDRAIN;
      end
      ST_SDRAIN: state_d = ST_OUT;
      ST_PREP1:  state_d = ST_PREP2;
      ST_PREP2: begin
        hit_clr = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        ram_raddr    = cell_addr(scx, scy, scz);
        probe.valid  = 1'b1;
        probe.box    = (kind_q == KIND_BOX);
        probe.box_ok = {box_axis(taz_q, tbz_q, scz), box_axis(tay_q, tby_q, scy),
                        box_axis(tax_q, tbx_q, scx)};
        probe.dx     = axis_dist(tax_q, scx);
        probe.dy     = axis_dist(tay_q, scy);
        probe.dz     = axis_dist(taz_q, scz);
        if (scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_q == '0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (push) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // clear / fill row / surround tag counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == ST_CLEAR || state_q == ST_FILL || state_q == ST_SURR) begin
      cnt_q <= cnt_q + ADDR_W'(1);
    end else if (state_q == ST_IDLE) begin
      cnt_q <= '0;
    end
  end

  // origin registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: org_y_q <= cfg_data_i;
        CFG_ORIGIN_Z: org_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // item capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_READ;
    end else if (accept) begin
      kind_q <= kind_e'(s_axis_tuser);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q  <= s_axis_tdata[3:0];
      cy_q  <= s_axis_tdata[7:4];
      cz_q  <= s_axis_tdata[11:8];
      val_q <= s_axis_tdata[19:12];
      ax_q  <= s_axis_tdata[51:20];
      ay_q  <= s_axis_tdata[83:52];
      az_q  <= s_axis_tdata[115:84];
      bx_q  <= s_axis_tdata[147:116];
      by_q  <= s_axis_tdata[179:148];
      bz_q  <= s_axis_tdata[211:180];
      rad_q <= s_axis_tdata[227:212];
    end
    if (state_q == ST_PREP1) begin
      tax_q <= rel_pos(ax_q, org_x_q);
      tay_q <= rel_pos(ay_q, org_y_q);
      taz_q <= rel_pos(az_q, org_z_q);
      tbx_q <= rel_pos(bx_q, org_x_q);
      tby_q <= rel_pos(by_q, org_y_q);
      tbz_q <= rel_pos(bz_q, org_z_q);
      r2_q  <= rad_q * rad_q;
    end
    if (state_q == ST_PREP2) begin
      rx_q <= clamp_cell(tax_q, CLAMP_HI);
      ry_q <= clamp_cell(tay_q, (kind_q == KIND_BOX) ? CLAMP_HI_BOX : CLAMP_HI);
      rz_q <= clamp_cell(taz_q, CLAMP_HI);
    end
  end

  // scan offsets and drain count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      drain_q <= '0;
    end else if (state_q == ST_PREP2) begin
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
    end else if (state_q == ST_SCAN) begin
      drain_q <= 2'd1;
      if (oz_q != OFF_LAST) begin
        oz_q <= oz_q + 2'd1;
      end else begin
        oz_q <= '0;
        if (ox_q != OFF_LAST) begin
          ox_q <= ox_q + 2'd1;
        end else begin
          ox_q <= '0;
          oy_q <= oy_q + 2'd1;
        end
      end
    end else if (state_q == ST_DRAIN && drain_q != '0) begin
      drain_q <= drain_q - 2'd1;
    end
  end

  // surround read return
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_tag_q <= NB_CENTER;
    end else begin
      rd_vld_q <= (state_q == ST_SURR);
      rd_tag_q <= cnt_q[2:0];
    end
  end

  // result assembly
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q      <= '0;
      surr_all_q <= 1'b1;
    end else begin
      if (state_q == ST_WB) begin
        res_q.block_type <= wr_en ? val_q[TYPE_W-1:0] : ram_rdata;
        res_q.changed    <= wr_en;
        res_q.rejected   <= (kind_q == KIND_WRITE) && (val_q > VAL_W'(3));
      end
      if (state_q == ST_FILL) begin
        res_q.block_type <= fill_type(cy_q, val_q);
      end
      if (rd_vld_q) begin
        if (rd_tag_q == NB_CENTER) begin
          res_q.block_type <= ram_rdata;
        end else if (ram_rdata == TYPE_EMPTY) begin
          surr_all_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_d = res_q;
    if (kind_q == KIND_SURR) out_d.surrounded = interior && surr_all_q;
    if (kind_q == KIND_SPHERE || kind_q == KIND_BOX) out_d.hit = hit;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_W-$bits(result_t)){1'b0}}, out_q};

  // no item taken before the clearing pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  // grid is not written while a scan reads it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_SURR) |-> !ram_we)
    else $error("grid write during read sequence");

  // a rejected write never reports a change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_d.rejected) |-> !out_d.changed)
    else $error("rejected write reported as changed");

endmodule

[rtl/vgs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vgs_ram #(
  parameter int unsigned DATA_W = 2,
  parameter int unsigned DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/vgs_hit.sv]
// Hit evaluation pipeline for sphere and box scans: squares, sum, compare, sticky hit.
// Depends on vgs_pkg.
module vgs_hit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  vgs_pkg::probe_t         probe_i,
  input  logic [vgs_pkg::TYPE_W-1:0] rdata_i,
  input  logic [vgs_pkg::R2_W-1:0]   r2_i,
  output logic                    hit_o
);
  import vgs_pkg::*;

  probe_t            p_q;
  logic              s_vld_q, s_box_q, s_box_ok_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]   sum;
  logic              cell_hit;
  logic              hit_q;

  // stage A: probe aligned with the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= probe_i;
    end
  end

  // stage B: occupancy and squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= p_q.valid && (rdata_i != TYPE_EMPTY);
    end
  end

  always_ff @(posedge clk_i) begin
    s_box_q    <= p_q.box;
    s_box_ok_q <= &p_q.box_ok;
    sqx_q      <= p_q.dx * p_q.dx;
    sqy_q      <= p_q.dy * p_q.dy;
    sqz_q      <= p_q.dz * p_q.dz;
  end

  // stage C: compare and accumulate
  assign sum      = sqx_q + sqy_q + sqz_q;
  assign cell_hit = s_box_q ? s_box_ok_q : (sum <= {{(SQ_W-R2_W){1'b0}}, r2_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (clr_i) begin
      hit_q <= 1'b0;
    end else if (s_vld_q && cell_hit) begin
      hit_q <= 1'b1;
    end
  end

  assign hit_o = hit_q;

endmodule
